// ----- src/rom_header_scorer_assert.svh -----
// Assertion macros used by the cartridge header scorer queue (rhs_queue).
// Each macro expands to one labeled concurrent assertion, disabled in reset.
`ifndef ROM_HEADER_SCORER_ASSERT_SVH
`define ROM_HEADER_SCORER_ASSERT_SVH

// Same-cycle implication.
`define RHS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RHS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/rhs_pkg.sv -----
// Types, codes and the opcode class table of the cartridge header scorer.
// No dependencies.
package rhs_pkg;

    localparam int IMG_W   = 25;
    localparam int SCORE_W = 5;

    // Candidate codes as they arrive on the input.
    localparam logic [1:0] CAND_LOW  = 2'd0;
    localparam logic [1:0] CAND_HIGH = 2'd1;
    localparam logic [1:0] CAND_EXT  = 2'd2;
    localparam logic [1:0] CAND_BAD  = 2'd3;

    // Location codes on the result.
    localparam logic [1:0] LOC_NONE = 2'd0;
    localparam logic [1:0] LOC_LOW  = 2'd1;
    localparam logic [1:0] LOC_HIGH = 2'd2;
    localparam logic [1:0] LOC_EXT  = 2'd3;

    // Header location plus 64 bytes: the image must be at least this long.
    localparam logic [IMG_W-1:0] END_LOW  = 25'h0008000;
    localparam logic [IMG_W-1:0] END_HIGH = 25'h0010000;
    localparam logic [IMG_W-1:0] END_EXT  = 25'h0410000;

    localparam logic [15:0] VEC_MIN     = 16'h8000;
    localparam logic [7:0]  FAST_MASK   = 8'hef;
    localparam logic [7:0]  MAP_LO_A    = 8'h20;
    localparam logic [7:0]  MAP_LO_B    = 8'h22;
    localparam logic [7:0]  MAP_HI      = 8'h21;
    localparam logic [7:0]  MAP_EX      = 8'h25;
    localparam logic [7:0]  COMPANY_EXT = 8'h33;
    localparam logic [7:0]  TYPE_LIM    = 8'h08;
    localparam logic [7:0]  ROM_LIM     = 8'h10;
    localparam logic [7:0]  RAM_LIM     = 8'h08;
    localparam logic [7:0]  REGION_LIM  = 8'd14;
    localparam logic [4:0]  EXT_BONUS   = 5'd4;

    localparam int MID_DEPTH = 4;
    localparam int MID_PTR_W = $clog2(MID_DEPTH);

    typedef struct packed {
        logic [1:0]         cand;
        logic [SCORE_W-1:0] score;
    } t_mid;

    typedef struct packed {
        logic [SCORE_W-1:0] score;
        logic               ready;
        logic [1:0]         loc;
    } t_result;

    // Points for the class of the first opcode at the reset vector.
    function automatic logic signed [5:0] opcode_points(input logic [7:0] op);
        logic signed [5:0] pts;
        unique case (op) inside
            8'h78, 8'h18, 8'h38, 8'h9c, 8'h4c, 8'h5c:
                pts = 6'sd8;
            8'hc2, 8'he2, 8'had, 8'hae, 8'hac, 8'haf, 8'ha9, 8'ha2, 8'ha0, 8'h20, 8'h22:
                pts = 6'sd4;
            8'h40, 8'h60, 8'h6b, 8'hcd, 8'hec, 8'hcc:
                pts = -6'sd4;
            8'h00, 8'h02, 8'hdb, 8'h42, 8'hff:
                pts = -6'sd8;
            default:
                pts = 6'sd0;
        endcase
        return pts;
    endfunction

endpackage

// ----- src/rhs_front.sv -----
// Front end: holds the image size and scores one header candidate per cycle.
// Depends on rhs_pkg.
module rhs_front
    import rhs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IMG_W-1:0] i_cfg_data,
    input  logic [1:0]       i_candidate,
    input  logic [15:0]      i_reset_vector,
    input  logic [7:0]       i_reset_opcode,
    input  logic [15:0]      i_checksum_word,
    input  logic [15:0]      i_complement_word,
    input  logic [7:0]       i_mapper_byte,
    input  logic [7:0]       i_company_byte,
    input  logic [7:0]       i_rom_type_byte,
    input  logic [7:0]       i_rom_size_byte,
    input  logic [7:0]       i_ram_size_byte,
    input  logic [7:0]       i_region_byte,
    output t_mid             o_item
);

    logic [IMG_W-1:0]  r_image_size;
    logic [IMG_W-1:0]  end_addr;
    logic [16:0]       chk_sum;
    logic [7:0]        map;
    logic              map_ok;
    logic              chk_ok;
    logic signed [5:0] raw;
    logic              zero_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_size <= '0;
        end else if (i_cfg_we) begin
            r_image_size <= i_cfg_data;
        end
    end

    always_comb begin
        unique case (i_candidate)
            CAND_LOW:  end_addr = END_LOW;
            CAND_HIGH: end_addr = END_HIGH;
            default:   end_addr = END_EXT;
        endcase
    end

    assign map     = i_mapper_byte & FAST_MASK;
    assign chk_sum = {1'b0, i_checksum_word} + {1'b0, i_complement_word};
    assign chk_ok  = (chk_sum == 17'h0ffff) && (i_checksum_word != '0)
                     && (i_complement_word != '0);

    always_comb begin
        unique case (i_candidate)
            CAND_LOW:  map_ok = (map == MAP_LO_A) || (map == MAP_LO_B);
            CAND_HIGH: map_ok = (map == MAP_HI);
            CAND_EXT:  map_ok = (map == MAP_EX);
            default:   map_ok = 1'b0;
        endcase
    end

    always_comb begin
        raw = opcode_points(i_reset_opcode);
        if (chk_ok) raw = raw + 6'sd4;
        if (map_ok) raw = raw + 6'sd2;
        if (i_company_byte == COMPANY_EXT) raw = raw + 6'sd2;
        raw = raw + $signed({5'd0, i_rom_type_byte < TYPE_LIM})
                  + $signed({5'd0, i_rom_size_byte < ROM_LIM})
                  + $signed({5'd0, i_ram_size_byte < RAM_LIM})
                  + $signed({5'd0, i_region_byte < REGION_LIM});
    end

    // An unknown candidate code, a short image, a low reset vector or a negative raw sum scores zero.
    assign zero_out = (i_candidate == CAND_BAD) || (r_image_size < end_addr)
                      || (i_reset_vector < VEC_MIN) || raw[5];

    assign o_item.cand  = i_candidate;
    assign o_item.score = zero_out ? '0 : raw[SCORE_W-1:0];

endmodule

// ----- src/rhs_queue.sv -----
// Four-entry flip-flop queue of scored candidates between front and back.
// Depends on rhs_pkg and the assertion macro header.
`include "rom_header_scorer_assert.svh"
module rhs_queue
    import rhs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_wr,
    input  t_mid i_wr_data,
    input  logic i_rd,
    output t_mid o_rd_data,
    output logic o_empty,
    output logic o_full
);

    t_mid                 r_mem [MID_DEPTH];
    logic [MID_PTR_W-1:0] r_wr_ptr;
    logic [MID_PTR_W-1:0] r_rd_ptr;
    logic [MID_PTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_wr) r_wr_ptr <= r_wr_ptr + 1'b1;
            if (i_rd) r_rd_ptr <= r_rd_ptr + 1'b1;
            if (i_wr && !i_rd) begin
                r_count <= r_count + 1'b1;
            end else if (i_rd && !i_wr) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_rd_data = r_mem[r_rd_ptr];
    assign o_empty   = (r_count == '0);
    assign o_full    = (r_count == (MID_PTR_W+1)'(MID_DEPTH));

    `RHS_ASSERT_IMP(a_no_overflow, i_clk, i_rst_n, i_wr, !o_full, "write into a full queue")
    `RHS_ASSERT_IMP(a_no_underflow, i_clk, i_rst_n, i_rd, !o_empty, "read from an empty queue")
    `RHS_ASSERT_IMP(a_ptr_count, i_clk, i_rst_n, 1'b1,
        ((r_wr_ptr - r_rd_ptr) == r_count[MID_PTR_W-1:0]) &&
        (r_count <= (MID_PTR_W+1)'(MID_DEPTH)), "queue pointers disagree with count")
    `RHS_ASSERT_NXT(a_count_up, i_clk, i_rst_n, i_wr && !i_rd,
        r_count == $past(r_count) + 1'b1, "count did not grow on a lone write")

endmodule

// ----- src/rhs_back.sv -----
// Back end: keeps the leading candidate, builds results, buffers them for pop.
// Depends on rhs_pkg.
module rhs_back
    import rhs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  t_mid    i_item,
    output logic    o_take,
    input  logic    i_pop,
    output logic    o_empty,
    output t_result o_result
);

    logic [SCORE_W-1:0] r_lead_score;
    logic [1:0]         r_lead_loc;
    logic [SCORE_W-1:0] n_lead_score;
    logic [1:0]         n_lead_loc;
    logic [SCORE_W-1:0] bonus;
    t_result            res;

    t_result            r_out [2];
    logic               r_wr_ptr;
    logic               r_rd_ptr;
    logic [1:0]         r_count;
    logic               pop_ok;

    assign pop_ok = i_pop && (r_count != 2'd0);
    assign o_take = i_valid && ((r_count != 2'd2) || pop_ok);
    assign bonus  = (i_item.score != '0) ? i_item.score + EXT_BONUS : '0;

    always_comb begin
        n_lead_score = r_lead_score;
        n_lead_loc   = r_lead_loc;
        res          = '0;
        unique case (i_item.cand)
            CAND_LOW: begin
                n_lead_score = i_item.score;
                n_lead_loc   = LOC_LOW;
                res.score    = i_item.score;
            end
            CAND_HIGH: begin
                if (i_item.score > r_lead_score) begin
                    n_lead_score = i_item.score;
                    n_lead_loc   = LOC_HIGH;
                end
                res.score = i_item.score;
            end
            CAND_EXT: begin
                if (bonus > r_lead_score) begin
                    n_lead_score = bonus;
                    n_lead_loc   = LOC_EXT;
                end
                res.score = i_item.score;
                res.ready = 1'b1;
                res.loc   = (n_lead_score != '0) ? n_lead_loc : LOC_NONE;
            end
            default: begin
                res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_take) begin
            r_out[r_wr_ptr] <= res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead_score <= '0;
            r_lead_loc   <= LOC_NONE;
            r_wr_ptr     <= 1'b0;
            r_rd_ptr     <= 1'b0;
            r_count      <= 2'd0;
        end else begin
            if (o_take) begin
                r_lead_score <= n_lead_score;
                r_lead_loc   <= n_lead_loc;
                r_wr_ptr     <= ~r_wr_ptr;
            end
            if (pop_ok) r_rd_ptr <= ~r_rd_ptr;
            if (o_take && !pop_ok) begin
                r_count <= r_count + 2'd1;
            end else if (pop_ok && !o_take) begin
                r_count <= r_count - 2'd1;
            end
        end
    end

    assign o_empty  = (r_count == 2'd0);
    assign o_result = r_out[r_rd_ptr];

endmodule

// ----- src/rom_header_scorer.sv -----
// Top level of the cartridge header scorer: front scorer, queue, back selector.
// Depends on rhs_pkg, rhs_front, rhs_queue and rhs_back.
//
//   Channel   Handshake             Payload
//   input     i_push / o_full       candidate and header bytes of one location
//   result    o_empty / i_pop       candidate score, decision flag, chosen location
//   config    i_cfg_we              image size in bytes
//
// One item per cycle is accepted while o_full is low, and one result per cycle can leave.
// The front scores an item in its push cycle and the four-entry queue registers
// it; the back takes it from the queue once its result buffer has room and registers the result.
// Reset is synchronous; it clears the image size, the leader and all queues.
// When pops stop, the back's two-entry result buffer fills, then the queue;
// o_full rises once four scored items wait in the queue.
module rom_header_scorer
    import rhs_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [IMG_W-1:0] i_cfg_data,
    input  logic             i_push,
    output logic             o_full,
    input  logic [1:0]       i_candidate,
    input  logic [15:0]      i_reset_vector,
    input  logic [7:0]       i_reset_opcode,
    input  logic [15:0]      i_checksum_word,
    input  logic [15:0]      i_complement_word,
    input  logic [7:0]       i_mapper_byte,
    input  logic [7:0]       i_company_byte,
    input  logic [7:0]       i_rom_type_byte,
    input  logic [7:0]       i_rom_size_byte,
    input  logic [7:0]       i_ram_size_byte,
    input  logic [7:0]       i_region_byte,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [4:0]       o_candidate_score,
    output logic             o_decision_ready,
    output logic [1:0]       o_chosen_location
);

    t_mid    front_item;
    t_mid    head_item;
    t_result result;
    logic    mid_empty;
    logic    mid_full;
    logic    back_take;
    logic    push_ok;

    assign push_ok = i_push && !mid_full;
    assign o_full  = mid_full;

    rhs_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_candidate       (i_candidate),
        .i_reset_vector    (i_reset_vector),
        .i_reset_opcode    (i_reset_opcode),
        .i_checksum_word   (i_checksum_word),
        .i_complement_word (i_complement_word),
        .i_mapper_byte     (i_mapper_byte),
        .i_company_byte    (i_company_byte),
        .i_rom_type_byte   (i_rom_type_byte),
        .i_rom_size_byte   (i_rom_size_byte),
        .i_ram_size_byte   (i_ram_size_byte),
        .i_region_byte     (i_region_byte),
        .o_item            (front_item)
    );

    rhs_queue u_queue (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (push_ok),
        .i_wr_data (front_item),
        .i_rd      (back_take),
        .o_rd_data (head_item),
        .o_empty   (mid_empty),
        .o_full    (mid_full)
    );

    rhs_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (!mid_empty),
        .i_item   (head_item),
        .o_take   (back_take),
        .i_pop    (i_pop),
        .o_empty  (o_empty),
        .o_result (result)
    );

    assign o_candidate_score = result.score;
    assign o_decision_ready  = result.ready;
    assign o_chosen_location = result.loc;

endmodule
